// File: design/jjy_pkg.sv
// Package for the JJY time code frame encoder: transfer payload types,
// pulse-width constants and the decimal digit split used to build the frame.
// No dependencies.
`timescale 1ns / 1ps

package jjy_pkg;

  localparam int unsigned MsWidth = 10;

  localparam logic [MsWidth-1:0] MsMarker = 10'd200;
  localparam logic [MsWidth-1:0] MsOne    = 10'd500;
  localparam logic [MsWidth-1:0] MsZero   = 10'd800;

  // Frame bit positions; second s carries frame bit (59 - s).
  localparam int unsigned FrameBits = 60;
  localparam int unsigned PosMinute = 59 - 8;
  localparam int unsigned PosHour   = 59 - 18;
  localparam int unsigned PosDay    = 59 - 33;
  localparam int unsigned PosYear   = 59 - 48;
  localparam int unsigned PosWday   = 59 - 52;
  localparam int unsigned PosPa1    = 59 - 36;
  localparam int unsigned PosPa2    = 59 - 37;

  typedef struct packed {
    logic [5:0] minute_of_hour;
    logic [4:0] hour_of_day;
    logic [8:0] day_of_year;
    logic [6:0] year_of_century;
    logic [2:0] weekday;
    logic [5:0] second_index;
  } jjy_in_t;

  typedef struct packed {
    logic [MsWidth-1:0] high_ms;
    logic               is_marker;
    logic               code_bit;
  } jjy_out_t;

  // Padded BCD of a value below 512: hundreds in [12:10], tens in [8:5],
  // ones in [3:0], zero bits between the groups. The quotients come from
  // reciprocal multiplies that are exact over this input range.
  function automatic logic [12:0] pad_bcd(input logic [8:0] v);
    logic [16:0] p10;
    logic [14:0] p100;
    logic [5:0]  q;
    logic [2:0]  h;
    logic [3:0]  ones;
    logic [3:0]  tens;
    p10  = 17'(v) * 17'd205;
    p100 = 15'(v) * 15'd41;
    q    = p10[16:11];
    h    = p100[14:12];
    // The digits are below ten, so four result bits of each subtraction suffice.
    ones = v[3:0] - ({q[0], 3'b000} + {q[2:0], 1'b0});
    tens = q[3:0] - ({h[0], 3'b000} + {h[2:0], 1'b0});
    return {h, 1'b0, tens, 1'b0, ones};
  endfunction

endpackage

// File: design/jjy_time_code_frame_encoder.sv
// JJY time code frame encoder, top level.
// Depends on jjy_pkg for payload types, constants and the BCD digit split.
`timescale 1ns / 1ps

// The encoder takes one broken-down time and second index per transfer and
// returns the high-carrier duration for that second of the JJY minute frame.
// It accepts one item every clock cycle unless in_stall_o is high; a result
// passes through two registers, the input register and the result register,
// with the whole frame built by the logic between the two. Stall on the
// output side holds the result register and is passed back to the input as
// soon as both registers are full. Markers are second 0, seconds ending in 9
// and seconds above 59; service announcement bits are always zero.
module jjy_time_code_frame_encoder
  import jjy_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  jjy_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output jjy_out_t out_data_o
);

  logic     in_valid_q, in_valid_d;
  jjy_in_t  in_data_q;
  logic     out_valid_q, out_valid_d;
  jjy_out_t out_data_q, out_data_d;

  logic out_free;
  logic in_take;

  logic [12:0] pad_min;
  logic [12:0] pad_hour;
  logic [12:0] pad_day;
  logic [12:0] pad_year;
  logic [6:0]  year_mod;
  logic [63:0] frame;
  logic [5:0]  bit_idx;
  logic        marker;
  logic        frame_bit;

  // Handshake and pipeline control.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = in_stall_o ? in_valid_q : in_valid_i;
    out_valid_d = out_free ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
    if (out_free && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  // Frame construction from the registered item.
  always_comb begin
    year_mod = (in_data_q.year_of_century >= 7'd100) ?
               (in_data_q.year_of_century - 7'd100) : in_data_q.year_of_century;
    pad_min  = pad_bcd({3'b000, in_data_q.minute_of_hour});
    pad_hour = pad_bcd({4'b0000, in_data_q.hour_of_day});
    pad_day  = pad_bcd(in_data_q.day_of_year);
    pad_year = pad_bcd({2'b00, year_mod});

    frame = '0;
    frame[PosMinute +: 8] = pad_min[7:0];
    frame[PosHour +: 7]   = pad_hour[6:0];
    frame[PosDay +: 13]   = pad_day;
    frame[PosYear +: 8]   = {pad_year[8:5], pad_year[3:0]};
    frame[PosWday +: 3]   = in_data_q.weekday;
    frame[PosPa1]         = ^pad_hour[6:0];
    frame[PosPa2]         = ^pad_min[7:0];

    marker = (in_data_q.second_index == 6'd0)  || (in_data_q.second_index == 6'd9)  ||
             (in_data_q.second_index == 6'd19) || (in_data_q.second_index == 6'd29) ||
             (in_data_q.second_index == 6'd39) || (in_data_q.second_index == 6'd49) ||
             (in_data_q.second_index >= 6'd59);

    // For seconds above 59 the index wraps into the zero padding of the frame.
    bit_idx   = 6'(FrameBits - 1) - in_data_q.second_index;
    frame_bit = frame[bit_idx] && !marker;

    out_data_d.is_marker = marker;
    out_data_d.code_bit  = frame_bit;
    out_data_d.high_ms   = marker ? MsMarker : (frame_bit ? MsOne : MsZero);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_marker |->
      out_data_o.high_ms == MsMarker && !out_data_o.code_bit)
    else $error("marker result with wrong duration or bit");

  a_data_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_marker |->
      out_data_o.high_ms == (out_data_o.code_bit ? MsOne : MsZero))
    else $error("data bit duration does not match code bit");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_free |=> out_valid_q)
    else $error("registered item did not reach the result register");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled while the pipeline can move");
`endif

endmodule
